// ----- rtl/core/l4_dest_port_blocklist_filter_core_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef L4_DEST_PORT_BLOCKLIST_FILTER_CORE_ASSERT_SVH
`define L4_DEST_PORT_BLOCKLIST_FILTER_CORE_ASSERT_SVH

// Same-cycle implication: when cond holds, expr must hold at that edge.
`define L4DPF_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("l4dpf assertion failed");

// Next-cycle implication: when cond holds, expr must hold at the next edge.
`define L4DPF_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("l4dpf assertion failed");

`endif

// ----- rtl/core/l4dpf_pkg.sv -----
package l4dpf_pkg;

   localparam int NUM_BLOCKED_DEF = 16;
   localparam int ENTRY_SLOTS     = 16;
   localparam int PORTS_PER_REG   = 4;
   localparam int NUM_REGS        = ENTRY_SLOTS / PORTS_PER_REG;
   localparam int PORT_W          = 16;
   localparam int REG_W           = PORTS_PER_REG * PORT_W;
   localparam int CSR_ADDR_W      = 5;
   localparam int COUNT_W         = 6;

   localparam logic [COUNT_W-1:0] COUNT_CAP    = 6'd54;
   localparam logic [COUNT_W-1:0] TCP_MIN_LEN  = 6'd54;
   localparam logic [COUNT_W-1:0] UDP_MIN_LEN  = 6'd42;
   localparam logic [COUNT_W-1:0] OFS_ETYPE_HI = 6'd12;
   localparam logic [COUNT_W-1:0] OFS_ETYPE_LO = 6'd13;
   localparam logic [COUNT_W-1:0] OFS_PROTO    = 6'd23;
   localparam logic [COUNT_W-1:0] OFS_DPORT_HI = 6'd36;
   localparam logic [COUNT_W-1:0] OFS_DPORT_LO = 6'd37;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   typedef struct packed {
      logic              drop_frame;
      logic [PORT_W-1:0] seen_port;
   } verdict_type;

   typedef struct packed {
      logic        valid;
      verdict_type verdict;
   } verdict_push_type;

endpackage

// ----- rtl/core/l4dpf_csr.sv -----
module l4dpf_csr
   import l4dpf_pkg::*;
(
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]                 csr_paddr,
   input  logic [REG_W-1:0]                      csr_pwdata,
   output logic [REG_W-1:0]                      csr_prdata,
   output logic                                  csr_pready,
   output logic [ENTRY_SLOTS-1:0][PORT_W-1:0]    entries
);

   logic [NUM_REGS-1:0][REG_W-1:0] regs_ff;
   logic [1:0]                     reg_idx;
   logic                           wr_en;

   // Registers sit at 8-byte strides; low address bits are ignored.
   assign reg_idx    = csr_paddr[4:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = regs_ff[reg_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else if (wr_en) begin
         regs_ff[reg_idx] <= csr_pwdata;
      end
   end

   for (genvar i = 0; i < ENTRY_SLOTS; i++) begin : g_entry
      assign entries[i] = regs_ff[i / PORTS_PER_REG][(i % PORTS_PER_REG) * PORT_W +: PORT_W];
   end

endmodule

// ----- rtl/core/l4dpf_parser.sv -----
module l4dpf_parser
   import l4dpf_pkg::*;
#(
   parameter int NUM_BLOCKED = NUM_BLOCKED_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [7:0]                          frame_byte,
   input  logic                                frame_end,
   input  logic [NUM_BLOCKED-1:0][PORT_W-1:0]  entries,
   output verdict_push_type                    push
);

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [15:0]        ether_type_ff, ether_type_in;
   logic [7:0]         ip_proto_ff, ip_proto_in;
   logic [15:0]        dest_port_ff, dest_port_in;
   logic               l4_valid;
   logic               listed;
   logic [PORT_W-1:0]  seen;

   always_comb begin
      ether_type_in = ether_type_ff;
      ip_proto_in   = ip_proto_ff;
      dest_port_in  = dest_port_ff;
      case (byte_count_ff)
         OFS_ETYPE_HI: ether_type_in = {frame_byte, ether_type_ff[7:0]};
         OFS_ETYPE_LO: ether_type_in = {ether_type_ff[15:8], frame_byte};
         OFS_PROTO:    ip_proto_in   = frame_byte;
         OFS_DPORT_HI: dest_port_in  = {frame_byte, dest_port_ff[7:0]};
         OFS_DPORT_LO: dest_port_in  = {dest_port_ff[15:8], frame_byte};
         default: ;
      endcase
      byte_count_in = (byte_count_ff < COUNT_CAP) ? byte_count_ff + 1'b1 : byte_count_ff;

      l4_valid = (ether_type_in == ETHERTYPE_IPV4) &&
                 (((ip_proto_in == PROTO_TCP) && (byte_count_in >= TCP_MIN_LEN)) ||
                  ((ip_proto_in == PROTO_UDP) && (byte_count_in >= UDP_MIN_LEN)));
      seen = l4_valid ? dest_port_in : '0;

      listed = 1'b0;
      for (int i = 0; i < NUM_BLOCKED; i++) begin
         listed = listed | (entries[i] == seen);
      end

      push.valid              = accept && frame_end;
      push.verdict.drop_frame = l4_valid && listed;
      push.verdict.seen_port  = seen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         ether_type_ff <= '0;
         ip_proto_ff   <= '0;
         dest_port_ff  <= '0;
      end else if (accept) begin
         if (frame_end) begin
            byte_count_ff <= '0;
            ether_type_ff <= '0;
            ip_proto_ff   <= '0;
            dest_port_ff  <= '0;
         end else begin
            byte_count_ff <= byte_count_in;
            ether_type_ff <= ether_type_in;
            ip_proto_ff   <= ip_proto_in;
            dest_port_ff  <= dest_port_in;
         end
      end
   end

endmodule

// ----- rtl/core/l4dpf_out_skid.sv -----
module l4dpf_out_skid
   import l4dpf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  verdict_push_type push,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output verdict_type      out_verdict
);

   logic        main_valid_ff;
   verdict_type main_ff;
   logic        skid_valid_ff;
   verdict_type skid_ff;
   logic        pop;

   assign in_ready    = !skid_valid_ff;
   assign out_valid   = main_valid_ff;
   assign out_verdict = main_ff;
   assign pop         = main_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff) begin
         main_valid_ff <= push.valid;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push.valid;
         end
      end else if (push.valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || (pop && !skid_valid_ff)) begin
         main_ff <= push.verdict;
      end else if (pop) begin
         main_ff <= skid_ff;
      end
      if (main_valid_ff && !pop && push.valid) begin
         skid_ff <= push.verdict;
      end
   end

endmodule

// ----- rtl/core/l4_dest_port_blocklist_filter_core.sv -----
// IPv4 TCP/UDP destination-port blocklist filter. Feed an Ethernet frame one
// byte per item in wire order and flag its last byte with req_frame_end; the
// block takes one byte every cycle while req_ready is high and gives one
// verdict per frame, registered when the last byte is accepted. The EtherType
// comes from bytes 12-13, the IPv4 protocol from byte 23 and the destination
// port from bytes 36-37, assuming a 20-byte IPv4 header. A frame is dropped
// when it is IPv4 TCP of at least 54 bytes or UDP of at least 42 bytes and its
// port matches one of the NUM_BLOCKED entries; rsp_seen_port is 0 for frames
// without a usable port. Rate: one item per cycle while req_ready is high, set
// by the single parse/compare pass between the frame state registers and the
// result register. The result register is backed by a one-entry skid stage,
// so req_ready drops only when two verdicts are held unread. All entries reset
// to zero, so port 0 is blocked until the table is written. Four 64-bit
// registers at byte addresses 0, 8, 16 and 24 each hold four 16-bit entries,
// lowest entry in bits 15:0; write them only while no frame is in flight.
module l4_dest_port_blocklist_filter_core
   import l4dpf_pkg::*;
#(
   parameter int NUM_BLOCKED = NUM_BLOCKED_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_frame_byte,
   input  logic                  req_frame_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_drop_frame,
   output logic [15:0]           rsp_seen_port,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [REG_W-1:0]      csr_pwdata,
   output logic [REG_W-1:0]      csr_prdata,
   output logic                  csr_pready
);

   logic [ENTRY_SLOTS-1:0][PORT_W-1:0] entries_all;
   logic                               accept;
   verdict_push_type                   push;
   verdict_type                        out_verdict;

   // Blocklist table.
   l4dpf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .entries     (entries_all)
   );

   // Advance the frame state on every accepted item.
   assign accept = req_valid && req_ready;

   // Parse the byte and, on the last one, compare against the active entries.
   l4dpf_parser #(
      .NUM_BLOCKED (NUM_BLOCKED)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .frame_byte (req_frame_byte),
      .frame_end  (req_frame_end),
      .entries    (entries_all[NUM_BLOCKED-1:0]),
      .push       (push)
   );

   // Hold verdicts until taken; backpressure only when both slots are full.
   l4dpf_out_skid u_out_skid (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .in_ready    (req_ready),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_verdict (out_verdict)
   );

   assign rsp_drop_frame = out_verdict.drop_frame;
   assign rsp_seen_port  = out_verdict.seen_port;

endmodule

// ----- rtl/core/l4dpf_checker.sv -----
`include "l4_dest_port_blocklist_filter_core_assert.svh"

module l4dpf_checker
   import l4dpf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_frame_end,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_drop_frame,
   input logic [15:0]           rsp_seen_port,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [REG_W-1:0]      csr_pwdata,
   input logic [REG_W-1:0]      csr_prdata,
   input logic                  csr_pready
);

   // A stalled verdict holds its payload.
   `L4DPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_drop_frame) && $stable(rsp_seen_port))

   // A new verdict appears only after a last byte was accepted.
   `L4DPF_ASSERT_NOW(a_rsp_from_last, clock, reset, $rose(rsp_valid),
      $past(req_valid && req_ready && req_frame_end))

   // Input backpressure only while a verdict is waiting at the output.
   `L4DPF_ASSERT_NOW(a_stall_needs_rsp, clock, reset, !req_ready, rsp_valid)

   // A register reads back what was just written to it.
   `L4DPF_ASSERT_NEXT(a_csr_readback, clock, reset,
      csr_psel && csr_penable && csr_pwrite && csr_pready,
      !(csr_psel && !csr_pwrite && (csr_paddr[4:3] == $past(csr_paddr[4:3]))) ||
      (csr_prdata == $past(csr_pwdata)))

endmodule

bind l4_dest_port_blocklist_filter_core l4dpf_checker u_l4dpf_checker (.*);

// ----- test/tb_l4_dest_port_blocklist_filter_core.sv -----
module tb_l4_dest_port_blocklist_filter_core;
   import l4dpf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BLOCKED = NUM_BLOCKED_DEF;

   // Codes that only this bench needs to build frames.
   localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
   localparam logic [7:0]  PROTO_ICMP     = 8'd1;

   // Length of the one long receiver hold-off that backs the block up.
   localparam int HOLD_CYCLES = 400;

   // Blocklist loaded in the middle of the directed part: every entry is
   // nonzero, so port 0 stops being blocked once it is in place.
   localparam logic [3:0][63:0] DIR_TBL = {
      64'hFFFF_FFFE_0002_0001,
      64'h8000_7FFF_0100_00FF,
      64'h1F90_0019_0017_0015,
      64'h0050_01BB_0016_0035
   };

   // A verdict typed in by hand; known = 0 means take the predictor's.
   typedef struct packed {
      bit          known;
      verdict_type v;
   } preset_verdict_type;

   // One row of the directed frame table.
   typedef struct packed {
      bit          load;    // load DIR_TBL before this frame
      logic [7:0]  len;
      logic [15:0] etype;
      logic [7:0]  proto;
      logic [15:0] port;
      bit          known;
      bit          drop;
      logic [15:0] seen;
   } frame_row_type;

   localparam int NUM_DIR = 23;

   frame_row_type dir_rows [NUM_DIR] = '{
      // reset table: all entries are zero, so port 0 is blocked
      '{1'b0, 8'd54,  ETHERTYPE_IPV4, PROTO_TCP,  16'h0000, 1'b1, 1'b1, 16'h0000},
      '{1'b0, 8'd42,  ETHERTYPE_IPV4, PROTO_UDP,  16'h0000, 1'b1, 1'b1, 16'h0000},
      '{1'b0, 8'd54,  ETHERTYPE_IPV4, PROTO_TCP,  16'h1234, 1'b1, 1'b0, 16'h1234},
      // too short for the L4 header: pass, no port
      '{1'b0, 8'd53,  ETHERTYPE_IPV4, PROTO_TCP,  16'h0000, 1'b1, 1'b0, 16'h0000},
      '{1'b0, 8'd41,  ETHERTYPE_IPV4, PROTO_UDP,  16'h0000, 1'b1, 1'b0, 16'h0000},
      '{1'b0, 8'd1,   ETHERTYPE_IPV4, PROTO_TCP,  16'h0000, 1'b1, 1'b0, 16'h0000},
      '{1'b0, 8'd13,  ETHERTYPE_IPV4, PROTO_UDP,  16'h0000, 1'b1, 1'b0, 16'h0000},
      '{1'b0, 8'd37,  ETHERTYPE_IPV4, PROTO_UDP,  16'h0000, 1'b1, 1'b0, 16'h0000},
      // other EtherType or protocol: pass, no port
      '{1'b0, 8'd54,  ETHERTYPE_IPV6, PROTO_TCP,  16'h0000, 1'b1, 1'b0, 16'h0000},
      '{1'b0, 8'd60,  ETHERTYPE_IPV4, PROTO_ICMP, 16'h0000, 1'b1, 1'b0, 16'h0000},
      // directed table in place
      '{1'b1, 8'd54,  ETHERTYPE_IPV4, PROTO_TCP,  16'h0050, 1'b1, 1'b1, 16'h0050},
      '{1'b0, 8'd42,  ETHERTYPE_IPV4, PROTO_UDP,  16'h0035, 1'b1, 1'b1, 16'h0035},
      '{1'b0, 8'd54,  ETHERTYPE_IPV4, PROTO_TCP,  16'h0000, 1'b1, 1'b0, 16'h0000},
      '{1'b0, 8'd64,  ETHERTYPE_IPV4, PROTO_TCP,  16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
      // long frame: counter saturates, trailing bytes ignored
      '{1'b0, 8'd120, ETHERTYPE_IPV4, PROTO_UDP,  16'h0001, 1'b1, 1'b1, 16'h0001},
      '{1'b0, 8'd54,  ETHERTYPE_IPV4, PROTO_TCP,  16'hFFFD, 1'b1, 1'b0, 16'hFFFD},
      '{1'b0, 8'd60,  16'h0801,       PROTO_UDP,  16'h0050, 1'b1, 1'b0, 16'h0000},
      '{1'b0, 8'd60,  16'h0008,       PROTO_UDP,  16'h0050, 1'b1, 1'b0, 16'h0000},
      '{1'b0, 8'd60,  ETHERTYPE_IPV4, 8'h86,      16'h0050, 1'b1, 1'b0, 16'h0000},
      '{1'b0, 8'd53,  ETHERTYPE_IPV4, PROTO_UDP,  16'h8000, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 8'd55,  ETHERTYPE_IPV4, PROTO_TCP,  16'h7FFF, 1'b0, 1'b0, 16'h0000},
      // TCP long enough for UDP but not for TCP
      '{1'b0, 8'd48,  ETHERTYPE_IPV4, PROTO_TCP,  16'h0050, 1'b1, 1'b0, 16'h0000},
      '{1'b0, 8'd44,  ETHERTYPE_IPV4, PROTO_UDP,  16'h00FF, 1'b0, 1'b0, 16'h0000}
   };

   // Block inputs, all known from time zero.
   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic [7:0]            req_frame_byte = '0;
   logic                  req_frame_end  = 1'b0;
   logic                  rsp_ready      = 1'b0;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [REG_W-1:0]      csr_pwdata     = '0;

   logic                  req_ready;
   logic                  rsp_valid;
   logic                  rsp_drop_frame;
   logic [15:0]           rsp_seen_port;
   logic [REG_W-1:0]      csr_prdata;
   logic                  csr_pready;

   // Predictor state: a private copy of the frame parser and the blocklist.
   logic [COUNT_W-1:0]    fr_count = '0;
   logic [15:0]           fr_etype = '0;
   logic [7:0]            fr_proto = '0;
   logic [15:0]           fr_dport = '0;
   logic [3:0][63:0]      blocked_tbl = '0;

   verdict_type           verdict_q [$];   // verdicts owed by the block, oldest first
   preset_verdict_type    preset_q [$];    // one per frame, pushed when the frame starts

   int                    err_count  = 0;
   int                    bytes_sent = 0;
   bit                    burst_mode  = 1'b0;
   bit                    hold_req    = 1'b0;
   bit                    hold_active = 1'b0;
   bit                    hold_done   = 1'b0;

   l4_dest_port_blocklist_filter_core #(
      .NUM_BLOCKED (NUM_BLOCKED)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_frame_byte (req_frame_byte),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_drop_frame (rsp_drop_frame),
      .rsp_seen_port  (rsp_seen_port),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #3_000_000;
      $display("[l4_dest_port_blocklist_filter_core] ERROR");
      $finish;
   end

   // Advance the parser by one byte; on the last byte return the verdict and
   // clear the frame state. Capture happens at the count seen before the
   // increment, so byte 12 lands when the counter reads 12.
   function automatic verdict_type parse_byte(input logic [7:0] b, input logic last);
      verdict_type v;
      logic        usable;
      v = '0;
      case (fr_count)
         OFS_ETYPE_HI: fr_etype[15:8] = b;
         OFS_ETYPE_LO: fr_etype[7:0]  = b;
         OFS_PROTO:    fr_proto       = b;
         OFS_DPORT_HI: fr_dport[15:8] = b;
         OFS_DPORT_LO: fr_dport[7:0]  = b;
         default: ;
      endcase
      if (fr_count < COUNT_CAP) fr_count = fr_count + 1'b1;
      if (last) begin
         usable = (fr_etype == ETHERTYPE_IPV4) &&
                  ((fr_proto == PROTO_TCP && fr_count >= TCP_MIN_LEN) ||
                   (fr_proto == PROTO_UDP && fr_count >= UDP_MIN_LEN));
         v.seen_port = usable ? fr_dport : 16'h0000;
         if (usable) begin
            for (int i = 0; i < NUM_BLOCKED; i++) begin
               if (blocked_tbl[i / 4][(i % 4) * 16 +: 16] == fr_dport) v.drop_frame = 1'b1;
            end
         end
         fr_count = '0;
         fr_etype = '0;
         fr_proto = '0;
         fr_dport = '0;
      end
      return v;
   endfunction

   // Gap length shared by both sides: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Monitor: feed every accepted byte to the predictor and check every
   // accepted verdict against the oldest one owed.
   always @(posedge clock) begin : monitor
      verdict_type        predicted;
      verdict_type        want;
      preset_verdict_type preset;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = parse_byte(req_frame_byte, req_frame_end);
            if (req_frame_end) begin
               preset = preset_q.pop_front();
               verdict_q.push_back(preset.known ? preset.v : predicted);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $error("unexpected verdict: drop_frame=%0b seen_port=%h",
                      rsp_drop_frame, rsp_seen_port);
               err_count++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_drop_frame !== want.drop_frame) begin
                  $error("drop_frame: expected %0b, actual %0b",
                         want.drop_frame, rsp_drop_frame);
                  err_count++;
               end
               if (rsp_seen_port !== want.seen_port) begin
                  $error("seen_port: expected %h, actual %h", want.seen_port, rsp_seen_port);
                  err_count++;
               end
            end
         end
      end
   end

   // Receiver: random stalls, long ready stretches, and one long hold-off
   // on request so the skid stage fills and the input stalls.
   initial begin : receiver
      int r;
      while (reset) @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (hold_req && !hold_done) begin
            hold_active = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
            hold_done   = 1'b1;
         end else if (r < 30) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end else if (r < 35) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(100, 300)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Offer one byte, with an optional gap before it, and hold it until taken.
   // Valid is lowered only when a gap follows, so back-to-back bytes keep it
   // high with a single assignment per step.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_frame_byte <= b;
      req_frame_end  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Build a frame of random filler with the header fields dropped in at
   // their offsets; bytes past the end of a short frame never go out.
   task automatic send_frame(input int len, input logic [15:0] et, input logic [7:0] pr,
                             input logic [15:0] pt, input preset_verdict_type pv);
      logic [7:0] b;
      preset_q.push_back(pv);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         case (i)
            12: b = et[15:8];
            13: b = et[7:0];
            23: b = pr;
            36: b = pt[15:8];
            37: b = pt[7:0];
            default: ;
         endcase
         send_byte(b, i == len - 1);
      end
   endtask

   // Mostly well-formed TCP/UDP frames near the length thresholds, hitting
   // listed ports half the time; the rest is broken headers, short frames,
   // a few long ones, and noise.
   task automatic random_frame();
      int          kind;
      int          len;
      int          base;
      logic [15:0] et;
      logic [7:0]  pr;
      logic [15:0] pt;
      kind = $urandom_range(0, 99);
      et   = ETHERTYPE_IPV4;
      pr   = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
      base = (pr == PROTO_TCP) ? int'(TCP_MIN_LEN) : int'(UDP_MIN_LEN);
      if ($urandom_range(0, 1))
         pt = blocked_tbl[$urandom_range(0, 3)][$urandom_range(0, 3) * 16 +: 16];
      else
         pt = 16'($urandom);
      len = base + $urandom_range(0, 12);
      if (kind < 8) begin
         len = base - 1;
      end else if (kind < 12) begin
         len = $urandom_range(65, 100);
      end else if (kind < 76) begin
         // well-formed as drawn
      end else if (kind < 82) begin
         et = ETHERTYPE_IPV4 ^ (16'h0001 << $urandom_range(0, 15));
      end else if (kind < 88) begin
         pr = pr ^ (8'h01 << $urandom_range(0, 7));
      end else if (kind < 94) begin
         len = $urandom_range(1, base - 1);
      end else begin
         len = $urandom_range(1, 60);
         et  = 16'($urandom);
         pr  = 8'($urandom);
      end
      send_frame(len, et, pr, pt, '0);
   endtask

   // Drop valid, let every owed verdict come back, then let the pipeline
   // settle before touching the registers.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all four entry registers back to back: setup, then access.
   task automatic load_blocklist(input logic [3:0][63:0] tbl);
      for (int r = 0; r < NUM_REGS; r++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= CSR_ADDR_W'(r * 8);
         csr_pwdata  <= tbl[r];
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         blocked_tbl[r] = tbl[r];
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [3:0][63:0]   tbl;
      logic [15:0]        p;
      preset_verdict_type pv;
      int                 start_cnt;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames, starting from the reset table.
      foreach (dir_rows[i]) begin
         if (dir_rows[i].load) begin
            wait_idle();
            load_blocklist(DIR_TBL);
         end
         pv.known        = dir_rows[i].known;
         pv.v.drop_frame = dir_rows[i].drop;
         pv.v.seen_port  = dir_rows[i].seen;
         send_frame(int'(dir_rows[i].len), dir_rows[i].etype, dir_rows[i].proto,
                    dir_rows[i].port, pv);
      end

      // Random phases, each under a different blocklist.
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase)
            0: tbl = '0;
            1: tbl = '1;
            3: begin
               p   = 16'($urandom);
               tbl = {16{p}};
            end
            4: begin
               for (int k = 0; k < ENTRY_SLOTS; k++)
                  tbl[k / 4][(k % 4) * 16 +: 16] = 16'($urandom_range(0, 1023));
            end
            default: begin
               for (int k = 0; k < NUM_REGS; k++) tbl[k] = {$urandom, $urandom};
            end
         endcase
         load_blocklist(tbl);
         start_cnt = bytes_sent;

         // Hold the receiver off and push short frames at full rate so the
         // verdicts pile up and the input stalls.
         if (phase == 2) begin
            hold_req = 1'b1;
            wait (hold_active);
            burst_mode = 1'b1;
            repeat (30) send_frame($urandom_range(1, 4), ETHERTYPE_IPV4, PROTO_UDP,
                                   16'h0000, '0);
            burst_mode = 1'b0;
         end

         while (bytes_sent - start_cnt < 20) random_frame();
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (err_count == 0)
         $display("[l4_dest_port_blocklist_filter_core] OK");
      else
         $display("[l4_dest_port_blocklist_filter_core] ERROR");
      $finish;
   end

endmodule
